// ===== hw/rtl/ret_pkg.sv =====
// ----------------------------------------------------------------------------
// ret_pkg: shared types and constants for the RPM envelope tracker
// Sequencer states, register map codes and fixed constants of the datapath.
// ----------------------------------------------------------------------------
package ret_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_FIX,
    ST_PCT,
    ST_DIV,
    ST_DONE
  } ret_state_t;

  // Register map: index is paddr[2]
  localparam int unsigned ADDR_W = 3;
  typedef enum logic [0:0] {
    REG_ALPHA   = 1'b0,
    REG_NOMINAL = 1'b1
  } ret_reg_t;

  // Field widths fixed by the interface
  localparam int unsigned RPM_IN_W   = 16;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned ALPHA_W    = 16;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;
  // Rounding bias for the downward move (ceiling of the scaled step)
  localparam logic [ALPHA_W-1:0] ROUND_BIAS  = 16'hFFFF;
  // Percentage carries 8 fraction bits
  localparam int unsigned PCT_FRAC_BITS = 8;
  // Headroom of spread*100
  localparam int unsigned PCT_MUL_BITS  = 7;

endpackage : ret_pkg

// ===== hw/rtl/ret_if.sv =====
// ----------------------------------------------------------------------------
// ret_if: valid/ready channels of the RPM envelope tracker
// One interface for the sample words and one for the result words.
// ----------------------------------------------------------------------------
interface ret_sample_if;
  logic                          valid;
  logic                          ready;
  logic [ret_pkg::RPM_IN_W-1:0]  rpm;

  modport source (output valid, output rpm, input ready);
  modport sink   (input valid, input rpm, output ready);
endinterface : ret_sample_if

interface ret_result_if;
  logic                        valid;
  logic                        ready;
  logic [ret_pkg::OUT_W-1:0]   low_track;
  logic [ret_pkg::OUT_W-1:0]   high_track;
  logic [ret_pkg::OUT_W-1:0]   spread;
  logic [ret_pkg::OUT_W-1:0]   spread_percent;

  modport source (output valid, output low_track, output high_track,
                  output spread, output spread_percent, input ready);
  modport sink   (input valid, input low_track, input high_track,
                  input spread, input spread_percent, output ready);
endinterface : ret_result_if

// ===== hw/rtl/rpm_envelope_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// rpm_envelope_tracker_unit: low/high envelope tracker for RPM samples
// Keeps two exponentially smoothed tracks around the measured speed and
// reports their spread, also as a percentage of a nominal speed.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one rpm word per handshake (valid/ready). ready is high only
//            while the sequencer is idle.
//   result : one word per sample with low_track, high_track, spread and
//            spread_percent, held in an output register until taken.
//   APB    : alpha at byte 0, nominal speed at byte 4; write only while idle.
// Timing: from acceptance to the result register a sample is worked by
//   two passes of a 16-step shift-add multiplier (alpha times track error),
//   a restoring divider with one quotient bit per cycle over NUM_W =
//   RPM_BITS + TRACK_FRAC_BITS + 7 bits, and the done state. A zero nominal
//   speed skips the divider, the seeding sample skips the multiplier. The
//   next sample can be taken at the earliest in the cycle after the result
//   register loads, so only one sample is in work at a time.
// Reset: both tracks clear, the first sample then seeds them; alpha returns
//   to 6554 and the nominal speed to 0.
// Stall: a new sample is taken while a result waits; the block holds its
//   next result in the done state until the output register is free.
// ----------------------------------------------------------------------------
module rpm_envelope_tracker_unit #(
  parameter int unsigned TRACK_FRAC_BITS = 16,
  parameter int unsigned RPM_BITS        = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  ret_sample_if.sink                        sample,
  ret_result_if.source                      result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ret_pkg::ADDR_W-1:0]        paddr,
  input  logic [ret_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ret_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int unsigned TW    = RPM_BITS + TRACK_FRAC_BITS;
  localparam int unsigned RIN_W = (RPM_BITS < ret_pkg::RPM_IN_W) ? RPM_BITS
                                                                  : ret_pkg::RPM_IN_W;
  localparam int unsigned PW    = TW + ret_pkg::ALPHA_W;
  localparam int unsigned NUM_W = TW + ret_pkg::PCT_MUL_BITS;
  localparam int unsigned DEN_SH = TRACK_FRAC_BITS - ret_pkg::PCT_FRAC_BITS;
  localparam int unsigned DEN_W = ret_pkg::ALPHA_W + DEN_SH;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  ret_pkg::ret_state_t state, state_next;

  // Configuration
  logic [ret_pkg::ALPHA_W-1:0] alpha;
  logic [ret_pkg::ALPHA_W-1:0] nom_speed;

  // Track state
  logic [TW-1:0] low_value;
  logic [TW-1:0] high_value;
  logic          seeded;

  // Working registers
  logic [TW-1:0]                rs;
  logic                         sel_hi;
  logic                         down;
  logic [PW-1:0]                mcand;
  logic [ret_pkg::ALPHA_W-1:0]  mplier;
  logic [PW-1:0]                acc;
  logic [CNT_W-1:0]             cnt;
  logic [NUM_W-1:0]             num;
  logic [DEN_W-1:0]             rem;
  logic [TW-1:0]                spread_r;
  logic [ret_pkg::OUT_W-1:0]    pct;

  // Output register
  logic                         res_valid;
  logic [ret_pkg::OUT_W-1:0]    res_low;
  logic [ret_pkg::OUT_W-1:0]    res_high;
  logic [ret_pkg::OUT_W-1:0]    res_spread;
  logic [ret_pkg::OUT_W-1:0]    res_pct;

  // Combinational helpers
  logic            in_fire;
  logic            cfg_wr;
  logic            out_free;
  logic [TW-1:0]   r_fix;
  logic [TW-1:0]   trk;
  logic [TW-1:0]   step;
  logic [TW-1:0]   moved;
  logic [TW-1:0]   clamped;
  logic [TW-1:0]   spread_c;
  logic [NUM_W-1:0] spread_x;
  logic [NUM_W-1:0] num_init;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   div_sh;
  logic             div_ge;
  logic [DEN_W:0]   div_diff;
  logic [63:0]      quot_x;
  logic             mul_last;
  logic             div_last;

  // Handshake and port outputs
  always_comb begin
    sample.ready = (state == ret_pkg::ST_IDLE);
    result.valid = res_valid;
    result.low_track      = res_low;
    result.high_track     = res_high;
    result.spread         = res_spread;
    result.spread_percent = res_pct;
    pready = 1'b1;
  end

  assign in_fire  = sample.valid && sample.ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !res_valid || result.ready;

  // Register readback
  always_comb begin
    case (ret_pkg::ret_reg_t'(paddr[2]))
      ret_pkg::REG_ALPHA:   prdata = ret_pkg::APB_DATA_W'(alpha);
      ret_pkg::REG_NOMINAL: prdata = ret_pkg::APB_DATA_W'(nom_speed);
      default:              prdata = '0;
    endcase
  end

  // Sample in track format, track under work, step and clamp
  always_comb begin
    r_fix    = TW'(sample.rpm[RIN_W-1:0]) << TRACK_FRAC_BITS;
    trk      = sel_hi ? high_value : low_value;
    step     = acc[PW-1:ret_pkg::ALPHA_W];
    moved    = down ? (trk - step) : (trk + step);
    if (sel_hi) begin
      clamped = (moved > rs) ? moved : rs;
    end else begin
      clamped = (moved < rs) ? moved : rs;
    end
    spread_c = (high_value >= low_value) ? (high_value - low_value) : '0;
    spread_x = NUM_W'(spread_c);
    num_init = (spread_x << 6) + (spread_x << 5) + (spread_x << 2);
    den      = DEN_W'(nom_speed) << DEN_SH;
    div_sh   = {rem, num[NUM_W-1]};
    div_ge   = div_sh >= {1'b0, den};
    div_diff = div_sh - {1'b0, den};
    quot_x   = 64'(num);
    mul_last = (cnt == CNT_W'(ret_pkg::ALPHA_W - 1));
    div_last = (cnt == CNT_W'(NUM_W - 1));
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ret_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = seeded ? ret_pkg::ST_SETUP : ret_pkg::ST_PCT;
        end
      end
      ret_pkg::ST_SETUP: state_next = ret_pkg::ST_MUL;
      ret_pkg::ST_MUL: begin
        if (mul_last) begin
          state_next = ret_pkg::ST_FIX;
        end
      end
      ret_pkg::ST_FIX: state_next = sel_hi ? ret_pkg::ST_PCT : ret_pkg::ST_SETUP;
      ret_pkg::ST_PCT: begin
        state_next = (nom_speed == '0) ? ret_pkg::ST_DONE : ret_pkg::ST_DIV;
      end
      ret_pkg::ST_DIV: begin
        if (div_last) begin
          state_next = ret_pkg::ST_DONE;
        end
      end
      ret_pkg::ST_DONE: begin
        // leave only once the quotient is saturated and the word is loaded
        if (out_free && cnt != CNT_W'(NUM_W)) begin
          state_next = ret_pkg::ST_IDLE;
        end
      end
      default: state_next = ret_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ret_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha     <= ret_pkg::ALPHA_RESET;
      nom_speed <= '0;
    end else if (cfg_wr) begin
      case (ret_pkg::ret_reg_t'(paddr[2]))
        ret_pkg::REG_ALPHA:   alpha     <= pwdata[ret_pkg::ALPHA_W-1:0];
        ret_pkg::REG_NOMINAL: nom_speed <= pwdata[ret_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // Track state: seed on the first sample, update after each fix step
  always_ff @(posedge clk) begin
    if (rst) begin
      low_value  <= '0;
      high_value <= '0;
      seeded     <= 1'b0;
    end else if (state == ret_pkg::ST_IDLE && in_fire && !seeded) begin
      low_value  <= r_fix;
      high_value <= r_fix;
      seeded     <= 1'b1;
    end else if (state == ret_pkg::ST_FIX) begin
      if (sel_hi) begin
        high_value <= clamped;
      end else begin
        low_value <= clamped;
      end
    end
  end

  // Datapath: shared shift-add multiplier and restoring divider
  always_ff @(posedge clk) begin
    case (state)
      ret_pkg::ST_IDLE: begin
        rs     <= r_fix;
        sel_hi <= 1'b0;
      end
      ret_pkg::ST_SETUP: begin
        // error magnitude and direction of the move
        down   <= rs < trk;
        mcand  <= PW'((rs < trk) ? (trk - rs) : (rs - trk));
        mplier <= alpha;
        acc    <= (rs < trk) ? PW'(ret_pkg::ROUND_BIAS) : '0;
        cnt    <= '0;
      end
      ret_pkg::ST_MUL: begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
      end
      ret_pkg::ST_FIX: begin
        sel_hi <= 1'b1;
      end
      ret_pkg::ST_PCT: begin
        spread_r <= spread_c;
        num      <= num_init;
        rem      <= '0;
        cnt      <= '0;
        pct      <= '0;
      end
      ret_pkg::ST_DIV: begin
        rem <= div_ge ? div_diff[DEN_W-1:0] : div_sh[DEN_W-1:0];
        num <= {num[NUM_W-2:0], div_ge};
        // mark the quotient complete after the last bit
        cnt <= div_last ? CNT_W'(NUM_W) : cnt + 1'b1;
      end
      ret_pkg::ST_DONE: begin
        // saturate the quotient once it is complete
        if (cnt == CNT_W'(NUM_W)) begin
          pct <= (|quot_x[63:32]) ? '1 : quot_x[31:0];
          cnt <= '0;
        end
      end
      default: ;
    endcase
  end

  // Output register: load when the result word is complete and free
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ret_pkg::ST_DONE && out_free && cnt != CNT_W'(NUM_W)) begin
      res_valid <= 1'b1;
    end else if (res_valid && result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ret_pkg::ST_DONE && out_free && cnt != CNT_W'(NUM_W)) begin
      res_low    <= ret_pkg::OUT_W'(low_value);
      res_high   <= ret_pkg::OUT_W'(high_value);
      res_spread <= ret_pkg::OUT_W'(spread_r);
      res_pct    <= pct;
    end
  end

endmodule : rpm_envelope_tracker_unit

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for rpm_envelope_tracker_unit
// Feeds RPM words through the sample channel and checks every result word
// against an in-bench envelope predictor, with random gaps and stalls on
// both channels and alpha / nominal speed changed over APB between phases.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned TRK_FRAC    = 16;
  localparam logic [63:0] TRACK_MASK  = 64'hFFFF_FFFF;
  localparam logic [63:0] PCT_MAX     = 64'hFFFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [ret_pkg::OUT_W-1:0] low_track;
    logic [ret_pkg::OUT_W-1:0] high_track;
    logic [ret_pkg::OUT_W-1:0] spread;
    logic [ret_pkg::OUT_W-1:0] spread_percent;
  } envelope_t;

  logic clk = 1'b0;
  logic rst;

  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [ret_pkg::ADDR_W-1:0]     paddr;
  logic [ret_pkg::APB_DATA_W-1:0] pwdata;
  logic [ret_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  ret_sample_if sample_ch ();
  ret_result_if result_ch ();

  rpm_envelope_tracker_unit dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Pending rpm words and the envelopes they must produce
  logic [ret_pkg::RPM_IN_W-1:0] sample_q[$];
  envelope_t                    envelope_q[$];

  // Predictor state and register shadow
  logic [63:0]                 low_env;
  logic [63:0]                 high_env;
  logic                        env_seeded;
  logic [ret_pkg::ALPHA_W-1:0] cfg_alpha;
  logic [15:0]                 cfg_nominal;

  int  fail_count  = 0;
  int  cycle_count = 0;
  bit  idle_en     = 1'b1;
  int  gap_left    = 0;
  int  stall_left  = 0;

  // Move a track toward the target by alpha of the error, floor rounding upward, ceiling downward
  function automatic logic [63:0] smooth_toward(input logic [63:0] track,
                                                input logic [63:0] target);
    logic [63:0] err;
    logic [63:0] step;
    if (target >= track) begin
      err  = target - track;
      step = (cfg_alpha * err) >> 16;
      return (track + step) & TRACK_MASK;
    end
    err  = track - target;
    step = (cfg_alpha * err + 64'd65535) >> 16;
    return (track - step) & TRACK_MASK;
  endfunction

  // Fold one rpm word into the envelope and return the expected result word
  function automatic envelope_t advance_envelope(
      input logic [ret_pkg::RPM_IN_W-1:0] speed);
    logic [63:0] target;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] width;
    logic [63:0] pct;
    envelope_t   res;
    target = {48'd0, speed} << TRK_FRAC;
    if (!env_seeded) begin
      low_env    = target;
      high_env   = target;
      env_seeded = 1'b1;
    end else begin
      lo       = smooth_toward(low_env, target);
      hi       = smooth_toward(high_env, target);
      low_env  = (lo < target) ? lo : target;
      high_env = (hi > target) ? hi : target;
    end
    width = (high_env >= low_env) ? high_env - low_env : 64'd0;
    if (cfg_nominal == 16'd0) begin
      pct = 64'd0;
    end else begin
      pct = (width * 64'd100) /
            ({48'd0, cfg_nominal} << (TRK_FRAC - ret_pkg::PCT_FRAC_BITS));
      if (pct > PCT_MAX) pct = PCT_MAX;
    end
    res.low_track      = low_env[31:0];
    res.high_track     = high_env[31:0];
    res.spread         = width[31:0];
    res.spread_percent = pct[31:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [ret_pkg::OUT_W-1:0] want,
                             input logic [ret_pkg::OUT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Sample driver: predict on acceptance, then present the next word or idle
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      sample_ch.rpm   <= '0;
    end else begin
      if (sample_ch.valid && sample_ch.ready)
        envelope_q.push_back(advance_envelope(sample_ch.rpm));
      if (!sample_ch.valid || sample_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          sample_ch.valid <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 2);
          sample_ch.valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          sample_ch.valid <= 1'b1;
          sample_ch.rpm   <= sample_q.pop_front();
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each taken word with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (envelope_q.size() == 0) begin
          $display("%0t: result word with none expected, actual %h %h %h %h", $time,
                   result_ch.low_track, result_ch.high_track, result_ch.spread,
                   result_ch.spread_percent);
          fail_count++;
        end else begin
          envelope_t want;
          want = envelope_q.pop_front();
          check_field("low_track", want.low_track, result_ch.low_track);
          check_field("high_track", want.high_track, result_ch.high_track);
          check_field("spread", want.spread, result_ch.spread);
          check_field("spread_percent", want.spread_percent, result_ch.spread_percent);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words still expected", $time, envelope_q.size());
      $display("rpm_envelope_tracker_unit regression: fail");
      $finish;
    end
  end

  // Hold until every queued word is sent and every result is back
  task automatic wait_idle(input int settle);
    while (sample_q.size() != 0 || sample_ch.valid || envelope_q.size() != 0)
      @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // APB write: setup cycle then access cycle
  task automatic reg_write(input ret_pkg::ret_reg_t idx, input logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == ret_pkg::REG_ALPHA) cfg_alpha = value;
    else cfg_nominal = value;
  endtask

  // Random rpm words: mostly steady speeds with jitter, some ramps,
  // some full-range noise and some jumps between the extremes
  task automatic queue_samples(input int count);
    int remain;
    int seg_left;
    int pick;
    int base;
    int wobble;
    int spot;
    remain   = count;
    seg_left = 0;
    pick     = 0;
    base     = 0;
    wobble   = 1;
    while (remain > 0) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 40);
        pick     = $urandom_range(0, 9);
        base     = $urandom_range(0, 65535);
        wobble   = 1 << $urandom_range(0, 12);
      end
      if (pick < 5) begin
        spot = base + int'($urandom_range(0, 2 * wobble)) - wobble;
        if (spot < 0) spot = 0;
        if (spot > 65535) spot = 65535;
      end else if (pick < 7) begin
        spot = base;
        base = (base + wobble / 16 + 1) & 16'hFFFF;
      end else if (pick < 9) begin
        spot = $urandom_range(0, 65535);
      end else begin
        spot = $urandom_range(0, 1) ? 65535 : 0;
      end
      sample_q.push_back(spot[15:0]);
      seg_left--;
      remain--;
    end
  endtask

  initial begin
    int          ph;
    logic [15:0] new_alpha;
    logic [15:0] new_nominal;
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    low_env     = '0;
    high_env    = '0;
    env_seeded  = 1'b0;
    cfg_alpha   = ret_pkg::ALPHA_RESET;
    cfg_nominal = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: first word seeds, zero nominal forces percent to zero
    wait_idle(2);
    foreach (sample_q[i]) ; // queue starts empty
    sample_q.push_back(16'h1234);
    sample_q.push_back(16'hFFFF);
    sample_q.push_back(16'h0000);
    sample_q.push_back(16'hFFFF);
    sample_q.push_back(16'hFFFF);
    sample_q.push_back(16'h0000);
    sample_q.push_back(16'h8000);
    sample_q.push_back(16'h7FFF);

    // Full-weight alpha, smallest nonzero nominal
    wait_idle(4);
    reg_write(ret_pkg::REG_ALPHA, 16'hFFFF);
    reg_write(ret_pkg::REG_NOMINAL, 16'd1);
    sample_q.push_back(16'h0000);
    sample_q.push_back(16'hFFFF);
    sample_q.push_back(16'h0000);
    sample_q.push_back(16'hFFFF);
    sample_q.push_back(16'h5555);
    sample_q.push_back(16'hAAAA);

    // Zero alpha freezes the tracks apart from clamping, largest nominal
    wait_idle(4);
    reg_write(ret_pkg::REG_ALPHA, 16'd0);
    reg_write(ret_pkg::REG_NOMINAL, 16'hFFFF);
    sample_q.push_back(16'hFFFF);
    sample_q.push_back(16'h0000);
    sample_q.push_back(16'h1234);
    sample_q.push_back(16'hFFFF);

    // Smallest nonzero alpha
    wait_idle(4);
    reg_write(ret_pkg::REG_ALPHA, 16'd1);
    reg_write(ret_pkg::REG_NOMINAL, 16'd100);
    sample_q.push_back(16'h0001);
    sample_q.push_back(16'hFFFE);
    sample_q.push_back(16'h00FF);
    sample_q.push_back(16'hFF00);

    // Random phases; the last one runs without gaps or stalls
    for (ph = 0; ph < 6; ph++) begin
      wait_idle(4);
      if (ph == 5) idle_en = 1'b0;
      case (ph % 3)
        0:       new_alpha = 16'($urandom_range(0, 65535));
        1:       new_alpha = 16'($urandom_range(0, 2048));
        default: new_alpha = 16'($urandom_range(60000, 65535));
      endcase
      if (ph == 3) new_nominal = 16'd0;
      else if (ph == 4) new_nominal = 16'($urandom_range(1, 50));
      else new_nominal = 16'($urandom_range(0, 65535));
      reg_write(ret_pkg::REG_ALPHA, new_alpha);
      reg_write(ret_pkg::REG_NOMINAL, new_nominal);
      queue_samples(125);
      // hold the sender until every result is back, then carry on
      wait_idle(0);
      queue_samples(125);
    end

    wait_idle(100);
    if (fail_count == 0) begin
      $display("rpm_envelope_tracker_unit regression: pass");
    end else begin
      $display("rpm_envelope_tracker_unit regression: fail");
    end
    $finish;
  end

endmodule : testbench
